[rtl/rlpd_pkg.sv]
package rlpd_pkg;

  // Widths fixed by the byte format and the register file
  localparam int unsigned CFG_W = 18;
  localparam int unsigned PIXEL_COUNT_BITS_DEFAULT = 18;
  localparam int unsigned RUN_W = 5;
  localparam int unsigned COLOUR_W = 3;

  // Register defaults after reset (640 x 256 pixels)
  localparam logic [CFG_W-1:0] FRAME_PIXELS_RESET = 18'd163840;
  localparam logic [CFG_W-1:0] OUTPUT_CAPACITY_RESET = 18'd163840;

  // Register indexes on the write port
  typedef enum logic [0:0] {
    REG_FRAME_PIXELS    = 1'b0,
    REG_OUTPUT_CAPACITY = 1'b1
  } rlpd_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_STATUS
  } rlpd_state_e;

  // One compressed byte request
  typedef struct packed {
    logic [7:0] code_byte;
    logic       first_byte;
    logic       last_byte;
  } rlpd_in_t;

  // One decoded pixel or status result
  typedef struct packed {
    logic                pixel_valid;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                run_end;
    logic                image_done;
    logic                image_ok;
  } rlpd_out_t;

  // Compare flags from the shared adder
  typedef struct packed {
    logic over;   // sum passes the frame limit
    logic match;  // sum equals the frame size
  } rlpd_flags_t;

endpackage

[rtl/run_length_pixel_decoder.sv]
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+-----------------------------
// in       | in  | in_valid_i / in_stall_o   | in_item_i  (rlpd_in_t)
// out      | out | out_valid_o / out_stall_i | out_item_o (rlpd_out_t)
// cfg      | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A byte is accepted, given a count check on the shared adder, then N = 1..32
// pixels or one status result (none for a non-last byte after a failure). The
// same adder counts the run down, one pixel a cycle unless the output stalls.
// The input is stalled from accept until the last result of the byte is in
// the output register; the next byte is accepted while that result waits.
// Reset clears the count, the failure flag and the registers to defaults.
module run_length_pixel_decoder
  import rlpd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rlpd_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rlpd_out_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned SumW =
    ((PIXEL_COUNT_BITS > CFG_W) ? PIXEL_COUNT_BITS : CFG_W) + 1;

  rlpd_state_e state_q, state_d;
  logic [CFG_W-1:0] frame_q, cap_q;
  logic [PIXEL_COUNT_BITS-1:0] count_q, count_d;
  logic failed_q, failed_d;
  logic [7:0] code_q, code_d;
  logic last_q, last_d;
  logic ok_q, ok_d;
  logic [RUN_W-1:0] remain_q, remain_d;
  logic out_valid_q, out_valid_d;
  rlpd_out_t out_q, out_d;

  logic [SumW-1:0] alu_a, alu_b, alu_sum;
  logic alu_cin;
  rlpd_flags_t alu_flags;
  logic slot_free;
  logic run_last;

  rlpd_alu #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_alu (
    .a_i           (alu_a),
    .b_i           (alu_b),
    .cin_i         (alu_cin),
    .frame_pixels_i(frame_q),
    .sum_o         (alu_sum),
    .flags_o       (alu_flags)
  );

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign run_last    = (remain_q == '0);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FRAME_PIXELS_RESET;
      cap_q   <= OUTPUT_CAPACITY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_PIXELS:    frame_q <= cfg_data_i;
        REG_OUTPUT_CAPACITY: cap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, datapath control and output loading
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    failed_d    = failed_q;
    code_d      = code_q;
    last_d      = last_q;
    ok_d        = ok_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    // default adder use: count + run length
    alu_a       = SumW'(count_q);
    alu_b       = SumW'(code_q[RUN_W-1:0]);
    alu_cin     = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          code_d = in_item_i.code_byte;
          last_d = in_item_i.last_byte;
          if (in_item_i.first_byte) begin
            count_d  = '0;
            failed_d = 1'b0;
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (failed_q) begin
          state_d = last_q ? ST_STATUS : ST_IDLE;
        end else if ((cap_q < frame_q) || alu_flags.over) begin
          failed_d = 1'b1;
          state_d  = ST_STATUS;
        end else begin
          count_d  = alu_sum[PIXEL_COUNT_BITS-1:0];
          ok_d     = last_q && alu_flags.match;
          remain_d = code_q[RUN_W-1:0];
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // adder counts the run down
        alu_a   = SumW'(remain_q);
        alu_b   = '1;
        alu_cin = 1'b0;
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.pixel_valid  = 1'b1;
          out_d.pixel_colour = code_q[7:5];
          out_d.run_end      = run_last;
          out_d.image_done   = run_last && last_q;
          out_d.image_ok     = run_last && ok_q;
          remain_d           = alu_sum[RUN_W-1:0];
          if (run_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.pixel_valid  = 1'b0;
          out_d.pixel_colour = '0;
          out_d.run_end      = 1'b1;
          out_d.image_done   = last_q;
          out_d.image_ok     = 1'b0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    last_q   <= last_d;
    ok_q     <= ok_d;
    remain_q <= remain_d;
    out_q    <= out_d;
  end

endmodule

[rtl/rlpd_alu.sv]
module rlpd_alu
  import rlpd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEFAULT,
  localparam int unsigned SumW =
    ((PIXEL_COUNT_BITS > CFG_W) ? PIXEL_COUNT_BITS : CFG_W) + 1
) (
  input  logic [SumW-1:0]  a_i,
  input  logic [SumW-1:0]  b_i,
  input  logic             cin_i,
  input  logic [CFG_W-1:0] frame_pixels_i,
  output logic [SumW-1:0]  sum_o,
  output rlpd_flags_t      flags_o
);

  localparam logic [SumW-1:0] CountMax =
    {{(SumW-PIXEL_COUNT_BITS){1'b0}}, {PIXEL_COUNT_BITS{1'b1}}};

  logic [SumW-1:0] frame_w;
  logic [SumW-1:0] limit;

  // Limit is the frame size, clipped to what the counter can hold
  assign frame_w = SumW'(frame_pixels_i);
  assign limit   = (frame_w < CountMax) ? frame_w : CountMax;

  // Shared adder with carry in, plus its two compares
  assign sum_o         = a_i + b_i + SumW'(cin_i);
  assign flags_o.over  = (sum_o > limit);
  assign flags_o.match = (sum_o == frame_w);

endmodule

[rtl/rlpd_checker.sv]
module rlpd_checker
  import rlpd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input rlpd_out_t out_item_o
);

  // An accepted byte always keeps the input stalled for its check cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a byte");

  // Success is only reported together with image completion
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.image_ok) |-> out_item_o.image_done)
    else $error("image_ok without image_done");

  // Image completion only on the final result of a byte
  a_done_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.image_done) |-> out_item_o.run_end)
    else $error("image_done without run_end");

  // Status results close the byte, carry colour zero and never succeed
  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.pixel_valid) |->
      (out_item_o.run_end && (out_item_o.pixel_colour == '0) && !out_item_o.image_ok))
    else $error("malformed status result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output result changed while stalled");

endmodule

bind run_length_pixel_decoder rlpd_checker u_rlpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
